// ----- rtl/pmcc_pkg.sv -----
// shared constants and types for the pixel mask collision checker
package pmcc_pkg;

   localparam int MAX_WIDTH  = 32;
   localparam int MAX_HEIGHT = 32;
   localparam int MAX_FRAMES = 8;

   localparam int STORE_DEPTH = MAX_FRAMES * MAX_HEIGHT;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int CNT_BITS    = $clog2(MAX_HEIGHT + 1);
   localparam int SHIFT_BITS  = $clog2(MAX_WIDTH);
   localparam int SPAN_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int COORD_BITS  = 18;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // register indexes
   localparam logic [2:0] REG_A_WIDTH  = 3'd0;
   localparam logic [2:0] REG_A_HEIGHT = 3'd1;
   localparam logic [2:0] REG_A_FRAMES = 3'd2;
   localparam logic [2:0] REG_B_WIDTH  = 3'd3;
   localparam logic [2:0] REG_B_HEIGHT = 3'd4;
   localparam logic [2:0] REG_B_FRAMES = 3'd5;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_CHECK = 1'b1;
   localparam logic MAP_A    = 1'b0;
   localparam logic MAP_B    = 1'b1;

   typedef struct packed {
      logic [5:0] a_width;
      logic [5:0] a_height;
      logic [3:0] a_frames;
      logic [5:0] b_width;
      logic [5:0] b_height;
      logic [3:0] b_frames;
   } cfg_type;

endpackage

// ----- rtl/pixel_mask_collision_check.sv -----
// pixel mask collision checker: two mask stores and the row-scan sequencer
//
// Pixel-perfect sprite collision test. After reset the block clears both mask
// stores, one row of each per cycle, all 256 rows (MAX_FRAMES * MAX_HEIGHT)
// of each, and holds req_stall high meanwhile. A load transaction writes one
// mask row and leaves the block idle, ready for the next transaction. A check
// transaction forms the bounding boxes, runs the overlap test, then sends
// each overlapping row through the shared read-shift-and compare unit,
// compares the last row and hands the result to the output register once
// that register is free; a hit stops the scan early. The row scan is
// bounded by the single read port of each mask ram. No new transaction is
// taken while a check is running; the output register holds a finished
// result while the next transaction starts.
module pixel_mask_collision_check import pmcc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic                     req_load_map,
   input  logic [2:0]               req_load_frame,
   input  logic [4:0]               req_load_row,
   input  logic [31:0]              req_load_bits,
   input  logic [2:0]               req_a_frame,
   input  logic signed [15:0]       req_a_x,
   input  logic signed [15:0]       req_a_y,
   input  logic [2:0]               req_b_frame,
   input  logic signed [15:0]       req_b_x,
   input  logic signed [15:0]       req_b_y,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_BOX   = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   cfg_type cfg;

   pmcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // control registers
   logic [2:0]           state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic                 pending_ff, pending_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   // payload registers
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 hit_ff, hit_in;
   logic [2:0]           fa_ff, fa_in, fb_ff, fb_in;
   logic                 frame_ok_ff, frame_ok_in;
   logic signed [COORD_BITS-1:0] al_ff, al_in, at_ff, at_in, ar_ff, ar_in, ab_ff, ab_in;
   logic signed [COORD_BITS-1:0] bl_ff, bl_in, bt_ff, bt_in, br_ff, br_in, bb_ff, bb_in;
   logic [SHIFT_BITS-1:0] sha_ff, sha_in, shb_ff, shb_in;
   logic [SPAN_BITS-1:0]  span_ff, span_in;
   logic [ROW_BITS-1:0]   row_a_ff, row_a_in, row_b_ff, row_b_in;
   logic [CNT_BITS-1:0]   rows_ff, rows_in;

   // saturated configuration
   logic [5:0] aw, ah, bw, bh;
   logic [3:0] an, bn;

   assign aw = (cfg.a_width  > 6'(MAX_WIDTH))  ? 6'(MAX_WIDTH)  : cfg.a_width;
   assign ah = (cfg.a_height > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : cfg.a_height;
   assign an = (cfg.a_frames > 4'(MAX_FRAMES)) ? 4'(MAX_FRAMES) : cfg.a_frames;
   assign bw = (cfg.b_width  > 6'(MAX_WIDTH))  ? 6'(MAX_WIDTH)  : cfg.b_width;
   assign bh = (cfg.b_height > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : cfg.b_height;
   assign bn = (cfg.b_frames > 4'(MAX_FRAMES)) ? 4'(MAX_FRAMES) : cfg.b_frames;

   logic accept;
   logic is_load;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_load   = accept && (req_opcode == OP_LOAD);

   // mask stores
   logic                 clearing;
   logic                 we_a, we_b;
   logic [ADDR_BITS-1:0] waddr, load_addr, raddr_a, raddr_b;
   logic [MAX_WIDTH-1:0] wdata, rdata_a, rdata_b;

   assign clearing  = (state_ff == S_CLEAR);
   assign load_addr = ADDR_BITS'(int'(req_load_frame) * MAX_HEIGHT)
                      + ADDR_BITS'(req_load_row);
   assign we_a  = clearing || (is_load && req_load_map == MAP_A);
   assign we_b  = clearing || (is_load && req_load_map == MAP_B);
   assign waddr = clearing ? clr_ff : load_addr;
   assign wdata = clearing ? '0 : MAX_WIDTH'(req_load_bits);

   assign raddr_a = ADDR_BITS'(int'(fa_ff) * MAX_HEIGHT) + ADDR_BITS'(row_a_ff);
   assign raddr_b = ADDR_BITS'(int'(fb_ff) * MAX_HEIGHT) + ADDR_BITS'(row_b_ff);

   pmcc_ram #(.WIDTH(MAX_WIDTH), .DEPTH(STORE_DEPTH)) u_mask_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr_a),
      .rdata (rdata_a)
   );

   pmcc_ram #(.WIDTH(MAX_WIDTH), .DEPTH(STORE_DEPTH)) u_mask_b (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr_b),
      .rdata (rdata_b)
   );

   // box overlap terms
   logic                         overlap;
   logic signed [COORD_BITS-1:0] x1, x2, y1, y2, dx, dy, d_ab, d_ba, e_ab, e_ba;

   assign overlap = (al_ff < br_ff) && (ar_ff > bl_ff) && (at_ff < bb_ff) && (ab_ff > bt_ff);
   assign x1   = (al_ff > bl_ff) ? al_ff : bl_ff;
   assign y1   = (at_ff > bt_ff) ? at_ff : bt_ff;
   assign x2   = (ar_ff < br_ff) ? ar_ff : br_ff;
   assign y2   = (ab_ff < bb_ff) ? ab_ff : bb_ff;
   assign dx   = x2 - x1;
   assign dy   = y2 - y1;
   assign d_ab = al_ff - bl_ff;
   assign d_ba = bl_ff - al_ff;
   assign e_ab = at_ff - bt_ff;
   assign e_ba = bt_ff - at_ff;

   // shared row compare unit
   logic [MAX_WIDTH-1:0] span_mask;
   logic                 hit_now;
   logic                 issue;

   assign span_mask = (span_ff >= SPAN_BITS'(MAX_WIDTH)) ? '1
                      : MAX_WIDTH'((64'd1 << span_ff) - 64'd1);
   assign hit_now   = pending_ff && (|((rdata_a >> sha_ff) & (rdata_b >> shb_ff) & span_mask));
   assign issue     = (rows_ff != '0);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pending_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      hit_in       = hit_ff;
      fa_in        = fa_ff;
      fb_in        = fb_ff;
      frame_ok_in  = frame_ok_ff;
      al_in = al_ff;  at_in = at_ff;  ar_in = ar_ff;  ab_in = ab_ff;
      bl_in = bl_ff;  bt_in = bt_ff;  br_in = br_ff;  bb_in = bb_ff;
      sha_in   = sha_ff;
      shb_in   = shb_ff;
      span_in  = span_ff;
      row_a_in = row_a_ff;
      row_b_in = row_b_ff;
      rows_in  = rows_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_BITS'(STORE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && req_opcode == OP_CHECK) begin
               fa_in       = req_a_frame;
               fb_in       = req_b_frame;
               frame_ok_in = ({1'b0, req_a_frame} < an) && ({1'b0, req_b_frame} < bn);
               al_in = {{(COORD_BITS-16){req_a_x[15]}}, req_a_x};
               at_in = {{(COORD_BITS-16){req_a_y[15]}}, req_a_y};
               bl_in = {{(COORD_BITS-16){req_b_x[15]}}, req_b_x};
               bt_in = {{(COORD_BITS-16){req_b_y[15]}}, req_b_y};
               ar_in = {{(COORD_BITS-16){req_a_x[15]}}, req_a_x}
                       + signed'({{(COORD_BITS-6){1'b0}}, aw});
               ab_in = {{(COORD_BITS-16){req_a_y[15]}}, req_a_y}
                       + signed'({{(COORD_BITS-6){1'b0}}, ah});
               br_in = {{(COORD_BITS-16){req_b_x[15]}}, req_b_x}
                       + signed'({{(COORD_BITS-6){1'b0}}, bw});
               bb_in = {{(COORD_BITS-16){req_b_y[15]}}, req_b_y}
                       + signed'({{(COORD_BITS-6){1'b0}}, bh});
               state_in = S_BOX;
            end
         end
         S_BOX: begin
            // offsets of the overlap's top-left corner inside each sprite
            sha_in   = (al_ff > bl_ff) ? '0 : d_ba[SHIFT_BITS-1:0];
            shb_in   = (al_ff > bl_ff) ? d_ab[SHIFT_BITS-1:0] : '0;
            row_a_in = (at_ff > bt_ff) ? '0 : e_ba[ROW_BITS-1:0];
            row_b_in = (at_ff > bt_ff) ? e_ab[ROW_BITS-1:0] : '0;
            span_in  = dx[SPAN_BITS-1:0];
            rows_in  = dy[CNT_BITS-1:0];
            if (frame_ok_ff && overlap) begin
               state_in = S_SCAN;
            end else begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (hit_now) begin
               hit_in   = 1'b1;
               state_in = S_DONE;
            end else if (issue) begin
               pending_in = 1'b1;
               row_a_in   = row_a_ff + 1'b1;
               row_b_in   = row_b_ff + 1'b1;
               rows_in    = rows_ff - 1'b1;
            end else begin
               // last row compared without a hit, or no rows at all
               hit_in   = 1'b0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff  <= rsp_hit_in;
      hit_ff      <= hit_in;
      fa_ff       <= fa_in;
      fb_ff       <= fb_in;
      frame_ok_ff <= frame_ok_in;
      al_ff <= al_in;  at_ff <= at_in;  ar_ff <= ar_in;  ab_ff <= ab_in;
      bl_ff <= bl_in;  bt_ff <= bt_in;  br_ff <= br_in;  bb_ff <= bb_in;
      sha_ff   <= sha_in;
      shb_ff   <= shb_in;
      span_ff  <= span_in;
      row_a_ff <= row_a_in;
      row_b_ff <= row_b_in;
      rows_ff  <= rows_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

endmodule

// ----- rtl/pmcc_ram.sv -----
// generic single write port ram with registered read
module pmcc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/pmcc_csr.sv -----
// configuration registers behind the apb-style port
module pmcc_csr import pmcc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       wr_en;

   assign index  = paddr[4:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_A_WIDTH:  cfg_in.a_width  = pwdata[5:0];
            REG_A_HEIGHT: cfg_in.a_height = pwdata[5:0];
            REG_A_FRAMES: cfg_in.a_frames = pwdata[3:0];
            REG_B_WIDTH:  cfg_in.b_width  = pwdata[5:0];
            REG_B_HEIGHT: cfg_in.b_height = pwdata[5:0];
            REG_B_FRAMES: cfg_in.b_frames = pwdata[3:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.a_width  <= 6'(MAX_WIDTH);
         cfg_ff.a_height <= 6'(MAX_HEIGHT);
         cfg_ff.a_frames <= 4'(MAX_FRAMES);
         cfg_ff.b_width  <= 6'(MAX_WIDTH);
         cfg_ff.b_height <= 6'(MAX_HEIGHT);
         cfg_ff.b_frames <= 4'(MAX_FRAMES);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         REG_A_WIDTH:  prdata = CSR_DATA_BITS'(cfg_ff.a_width);
         REG_A_HEIGHT: prdata = CSR_DATA_BITS'(cfg_ff.a_height);
         REG_A_FRAMES: prdata = CSR_DATA_BITS'(cfg_ff.a_frames);
         REG_B_WIDTH:  prdata = CSR_DATA_BITS'(cfg_ff.b_width);
         REG_B_HEIGHT: prdata = CSR_DATA_BITS'(cfg_ff.b_height);
         REG_B_FRAMES: prdata = CSR_DATA_BITS'(cfg_ff.b_frames);
         default:      prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
